// ===== design/sstl_pkg.sv =====
`timescale 1ns / 1ps
package sstl_pkg;

  localparam int DEF_TABLE_ENTRIES = 128;
  localparam int DEF_KEY_BYTES     = 50;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  localparam logic [1:0] ST_STORED  = 2'd0;
  localparam logic [1:0] ST_DROPPED = 2'd1;
  localparam logic [1:0] ST_ANSWER  = 2'd2;

  typedef struct packed {
    logic       kind;
    logic [7:0] char_code;
    logic       last_char;
    logic [6:0] prob_first;
    logic [6:0] prob_last;
  } in_t;

  typedef struct packed {
    logic [1:0] status;
    logic       found;
    logic [6:0] match_index;
    logic       is_first_name;
    logic       is_last_name;
    logic       is_not_name;
  } out_t;

endpackage

// ===== design/sstl_ram.sv =====
`timescale 1ns / 1ps
module sstl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/sorted_string_table_lookup_flags_core.sv =====
`timescale 1ns / 1ps
// Intermediate character word: taken while idle, no result.
// Final load word: the tail of the row is zero-filled before the result (dropped if the table is full).
// Final query word: binary search comparing one key byte at a time (one key-store read port),
//   at most ceil(log2(TABLE_ENTRIES + 1)) probes, then the flags are fetched and the result emitted.
// Synchronous reset clears the table count and control; memories keep their contents.
module sorted_string_table_lookup_flags_core import sstl_pkg::*; #(
  parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
  parameter int KEY_BYTES     = DEF_KEY_BYTES
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  localparam int CW  = $clog2(TABLE_ENTRIES + 1);
  localparam int IW  = $clog2(TABLE_ENTRIES);
  localparam int PW  = $clog2(KEY_BYTES + 1);
  localparam int KAW = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
  localparam int KD  = (KEY_BYTES > 1) ? KEY_BYTES : 2;
  localparam int AW  = $clog2(TABLE_ENTRIES * KEY_BYTES);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_PROBE = 7'b0000010,
    S_RD    = 7'b0000100,
    S_CMP   = 7'b0001000,
    S_FLAG  = 7'b0010000,
    S_PAD   = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t        state;
  logic [CW-1:0] count;
  logic [AW-1:0] wr_base;
  logic [PW-1:0] pos;
  logic [PW-1:0] len;
  logic [PW-1:0] ci;
  logic [CW-1:0] lo;
  logic [CW-1:0] n;
  logic [CW-1:0] mid;
  logic [AW-1:0] probe_base;
  out_t          res;

  logic          accept;
  logic          char_ok;
  logic [PW-1:0] pos_inc;
  logic [CW-1:0] mid_next;
  logic [7:0]    pend_rd;
  logic [7:0]    key_rd;
  logic [7:0]    pend_byte;
  logic [1:0]    flag_rd;
  logic          key_we;
  logic [AW-1:0] key_waddr;
  logic [AW-1:0] key_raddr;
  logic          out_free;

  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid && (state == S_IDLE);
  assign char_ok   = (pos < PW'(KEY_BYTES));
  assign pos_inc   = char_ok ? pos + PW'(1) : pos;
  assign mid_next  = lo + ((n - CW'(1)) >> 1);
  assign pend_byte = (ci < len) ? pend_rd : 8'd0;
  assign out_free  = !out_valid || !out_stall;

  // Characters go straight into the next free row; pad the rest on commit.
  assign key_we    = (accept && char_ok && (count < CW'(TABLE_ENTRIES))) ||
                     ((state == S_PAD) && (ci < PW'(KEY_BYTES)));
  assign key_waddr = (state == S_PAD) ? wr_base + AW'(ci) : wr_base + AW'(pos);
  assign key_raddr = probe_base + AW'(ci);

  sstl_ram #(.WIDTH(8), .DEPTH(TABLE_ENTRIES * KEY_BYTES)) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (key_waddr),
    .wdata ((state == S_PAD) ? 8'd0 : in_data.char_code),
    .raddr (key_raddr),
    .rdata (key_rd)
  );

  sstl_ram #(.WIDTH(8), .DEPTH(KD)) u_pend_ram (
    .clk   (clk),
    .we    (accept && char_ok),
    .waddr (pos[KAW-1:0]),
    .wdata (in_data.char_code),
    .raddr (ci[KAW-1:0]),
    .rdata (pend_rd)
  );

  sstl_ram #(.WIDTH(2), .DEPTH(TABLE_ENTRIES)) u_flag_ram (
    .clk   (clk),
    .we    (accept && in_data.last_char && (in_data.kind == KIND_LOAD) &&
            (count < CW'(TABLE_ENTRIES))),
    .waddr (count[IW-1:0]),
    .wdata ({in_data.prob_last != 7'd0, in_data.prob_first != 7'd0}),
    .raddr (mid[IW-1:0]),
    .rdata (flag_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      wr_base   <= '0;
      pos       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (in_data.last_char) begin
              pos <= '0;
              len <= pos_inc;
              if (in_data.kind == KIND_LOAD) begin
                if (count >= CW'(TABLE_ENTRIES)) begin
                  res   <= '{status: ST_DROPPED, default: '0};
                  state <= S_DONE;
                end else begin
                  res   <= '{status: ST_STORED, match_index: 7'(count), default: '0};
                  ci    <= pos_inc;
                  state <= S_PAD;
                end
              end else begin
                res   <= '{status: ST_ANSWER, default: '0};
                lo    <= '0;
                n     <= count;
                state <= S_PROBE;
              end
            end else begin
              pos <= pos_inc;
            end
          end
        end
        S_PROBE: begin
          if (n == '0) begin
            res.is_not_name <= 1'b1;
            state           <= S_DONE;
          end else begin
            mid        <= mid_next;
            probe_base <= AW'(mid_next * KEY_BYTES);
            ci         <= '0;
            state      <= S_RD;
          end
        end
        S_RD: begin
          state <= S_CMP;
        end
        S_CMP: begin
          if (pend_byte != key_rd) begin
            if (pend_byte < key_rd) begin
              n <= mid - lo;
            end else begin
              n  <= n - (mid - lo) - CW'(1);
              lo <= mid + CW'(1);
            end
            state <= S_PROBE;
          end else if (pend_byte == 8'd0 || ci == PW'(KEY_BYTES - 1)) begin
            state <= S_FLAG;
          end else begin
            ci    <= ci + PW'(1);
            state <= S_RD;
          end
        end
        S_FLAG: begin
          res.found         <= 1'b1;
          res.match_index   <= 7'(mid);
          res.is_first_name <= flag_rd[0];
          res.is_last_name  <= flag_rd[1];
          res.is_not_name   <= !(flag_rd[0] || flag_rd[1]);
          state             <= S_DONE;
        end
        S_PAD: begin
          if (ci >= PW'(KEY_BYTES)) begin
            count   <= count + CW'(1);
            wr_base <= wr_base + AW'(KEY_BYTES);
            state   <= S_DONE;
          end else begin
            ci <= ci + PW'(1);
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Hold the word while stalled; load only from the finished result.
  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      out_data <= res;
    end
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
  import sstl_pkg::*;

  localparam int ENTRIES = DEF_TABLE_ENTRIES;
  localparam int KBYTES  = DEF_KEY_BYTES;
  localparam int CYCLE_LIMIT = 5000000;

  typedef logic [7:0] key_t[$];

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  sorted_string_table_lookup_flags_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  // Shadow copy of the table
  logic [7:0] tbl_key [ENTRIES][KBYTES];
  logic [1:0] tbl_flags [ENTRIES];
  int         tbl_count;
  logic [7:0] cur_key [KBYTES];
  int         cur_pos;

  in_t  word_q[$];
  out_t answer_q[$];
  int   errors;
  int   cycles;
  bit   quiet_mode;

  function automatic int probe_cmp(int idx);
    for (int i = 0; i < KBYTES; i++) begin
      if (cur_key[i] != tbl_key[idx][i]) return (cur_key[i] < tbl_key[idx][i]) ? -1 : 1;
      if (cur_key[i] == 8'd0) return 0;
    end
    return 0;
  endfunction

  task automatic predict_word(input in_t w);
    out_t r;
    int lo, n, mid, c;
    r = '0;
    if (cur_pos < KBYTES) begin
      cur_key[cur_pos] = w.char_code;
      cur_pos++;
    end
    if (!w.last_char) return;
    if (w.kind == KIND_LOAD) begin
      if (tbl_count >= ENTRIES) begin
        r.status = ST_DROPPED;
      end else begin
        for (int i = 0; i < KBYTES; i++) tbl_key[tbl_count][i] = cur_key[i];
        tbl_flags[tbl_count] = {w.prob_last != 0, w.prob_first != 0};
        r.status = ST_STORED;
        r.match_index = tbl_count[6:0];
        tbl_count++;
      end
    end else begin
      r.status = ST_ANSWER;
      lo = 0;
      n = tbl_count;
      while (n > 0) begin
        mid = lo + (n - 1) / 2;
        c = probe_cmp(mid);
        if (c == 0) begin
          r.found = 1'b1;
          r.match_index = mid[6:0];
          break;
        end else if (c < 0) begin
          n = mid - lo;
        end else begin
          n = n - (mid - lo) - 1;
          lo = mid + 1;
        end
      end
      if (r.found) begin
        r.is_first_name = tbl_flags[mid][0];
        r.is_last_name  = tbl_flags[mid][1];
      end
      r.is_not_name = !(r.is_first_name || r.is_last_name);
    end
    for (int i = 0; i < KBYTES; i++) cur_key[i] = 8'd0;
    cur_pos = 0;
    answer_q.push_back(r);
  endtask

  function automatic int pick_gap();
    int r;
    if (quiet_mode) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Driver
  int send_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) predict_word(in_data);
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (word_q.size() > 0) begin
        in_data <= word_q.pop_front();
        in_valid <= 1'b1;
        send_gap = pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
      if ($urandom_range(0, 299) == 0) quiet_mode = !quiet_mode;
    end
  end

  // Monitor
  int hold_cnt = 0;
  always @(posedge clk) begin
    out_t e;
    cycles++;
    if (!rst && out_valid && !out_stall) begin
      if (answer_q.size() == 0) begin
        $display("%0t: unexpected word %p", $time, out_data);
        errors++;
      end else begin
        e = answer_q.pop_front();
        if (e.status != out_data.status)
          $display("%0t: status exp %0d got %0d", $time, e.status, out_data.status);
        if (e.found != out_data.found)
          $display("%0t: found exp %0d got %0d", $time, e.found, out_data.found);
        if (e.match_index != out_data.match_index)
          $display("%0t: match_index exp %0d got %0d", $time, e.match_index,
                   out_data.match_index);
        if (e.is_first_name != out_data.is_first_name)
          $display("%0t: is_first_name exp %0d got %0d", $time, e.is_first_name,
                   out_data.is_first_name);
        if (e.is_last_name != out_data.is_last_name)
          $display("%0t: is_last_name exp %0d got %0d", $time, e.is_last_name,
                   out_data.is_last_name);
        if (e.is_not_name != out_data.is_not_name)
          $display("%0t: is_not_name exp %0d got %0d", $time, e.is_not_name,
                   out_data.is_not_name);
        if (e != out_data) errors++;
      end
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_stall <= 1'b1;
    end else begin
      hold_cnt = pick_gap();
      out_stall <= (hold_cnt > 0);
      if (hold_cnt > 0) hold_cnt--;
    end
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL sorted_string_table_lookup_flags_core");
      $finish;
    end
  end

  // Queue one key as a word sequence; mixed puts random kinds on the leading bytes
  task automatic send_key(input logic kind, input key_t k, input int pf, input int pl,
                          input bit mixed);
    in_t w;
    for (int i = 0; i < k.size(); i++) begin
      w.kind = (mixed && i < k.size() - 1) ? logic'($urandom_range(0, 1)) : kind;
      w.char_code = k[i];
      w.last_char = (i == k.size() - 1);
      w.prob_first = (i == k.size() - 1) ? pf[6:0] : 7'($urandom_range(0, 100));
      w.prob_last  = (i == k.size() - 1) ? pl[6:0] : 7'($urandom_range(0, 100));
      word_q.push_back(w);
    end
  endtask

  function automatic int key_order(key_t a, key_t b);
    logic [7:0] x, y;
    for (int i = 0; i < KBYTES; i++) begin
      x = (i < a.size()) ? a[i] : 8'd0;
      y = (i < b.size()) ? b[i] : 8'd0;
      if (x != y) return (x < y) ? -1 : 1;
      if (x == 8'd0) return 0;
    end
    return 0;
  endfunction

  function automatic key_t rand_key(int first_lo, bit zeros);
    key_t k;
    int len;
    len = ($urandom_range(0, 49) == 0) ? $urandom_range(5, 60) : $urandom_range(1, 2);
    for (int i = 0; i < len; i++) begin
      if (i == 0) k.push_back(8'($urandom_range(first_lo, 255)));
      else if (zeros && $urandom_range(0, 30) == 0) k.push_back(8'd0);
      else k.push_back(8'($urandom_range(1, 255)));
    end
    return k;
  endfunction

  key_t sorted_keys[$];
  key_t loaded[$];

  initial begin
    key_t k, lng;
    int pos;
    errors = 0;
    cycles = 0;
    quiet_mode = 0;
    tbl_count = 0;
    cur_pos = 0;
    for (int i = 0; i < KBYTES; i++) cur_key[i] = 8'd0;

    // Directed: empty table, ordered loads, hits, misses, overlong keys, mixed kinds
    send_key(KIND_QUERY, '{8'h41}, 0, 0, 0);
    send_key(KIND_LOAD, '{8'h01}, 0, 0, 0);
    lng = {};
    for (int i = 0; i < 51; i++) lng.push_back(8'h01);
    send_key(KIND_LOAD, lng, 100, 0, 0);
    send_key(KIND_LOAD, '{8'h02, 8'h05}, 0, 100, 0);
    send_key(KIND_LOAD, '{8'h03}, 100, 100, 0);
    send_key(KIND_LOAD, '{8'h04, 8'hff}, 64, 63, 1);
    send_key(KIND_QUERY, '{8'h01}, 0, 0, 0);
    send_key(KIND_QUERY, lng, 0, 0, 0);
    send_key(KIND_QUERY, '{8'h02, 8'h05}, 0, 0, 1);
    send_key(KIND_QUERY, '{8'h03}, 0, 0, 0);
    send_key(KIND_QUERY, '{8'h04, 8'hff}, 0, 0, 0);
    send_key(KIND_QUERY, '{8'h03, 8'h00, 8'h07}, 0, 0, 0);
    send_key(KIND_QUERY, '{8'hff, 8'h80}, 0, 0, 0);
    loaded = '{'{8'h01}, lng, '{8'h02, 8'h05}, '{8'h03}, '{8'h04, 8'hff}};

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Hold the sender until everything in flight has drained
    wait (word_q.size() == 0 && !in_valid && answer_q.size() == 0);

    for (int i = 0; i < 126; i++) begin
      k = rand_key(16, 0);
      pos = 0;
      while (pos < sorted_keys.size() && key_order(sorted_keys[pos], k) <= 0) pos++;
      sorted_keys.insert(pos, k);
    end
    for (int i = 0; i < 60; i++) begin
      if ($urandom_range(0, 1) && sorted_keys.size() > 0) begin
        k = sorted_keys.pop_front();
        loaded.push_back(k);
        send_key(KIND_LOAD, k, $urandom_range(0, 100), $urandom_range(0, 100),
                 $urandom_range(0, 9) == 0);
      end else if ($urandom_range(0, 1)) begin
        send_key(KIND_QUERY, loaded[$urandom_range(0, loaded.size() - 1)], 0, 0,
                 $urandom_range(0, 9) == 0);
      end else begin
        send_key(KIND_QUERY, rand_key(1, 1), 0, 0, $urandom_range(0, 9) == 0);
      end
    end
    // Fill the table and spill over
    while (sorted_keys.size() > 0) begin
      k = sorted_keys.pop_front();
      loaded.push_back(k);
      send_key(KIND_LOAD, k, $urandom_range(0, 1) * 100, $urandom_range(0, 100), 0);
    end
    for (int i = 0; i < 8; i++)
      send_key(KIND_QUERY, (i % 2) ? rand_key(1, 1) : loaded[$urandom_range(0, 127)],
               0, 0, 0);

    wait (word_q.size() == 0 && !in_valid && answer_q.size() == 0);
    repeat (1500) @(posedge clk);
    if (errors == 0 && answer_q.size() == 0) begin
      $display("PASS sorted_string_table_lookup_flags_core");
    end else begin
      $display("FAIL sorted_string_table_lookup_flags_core");
    end
    $finish;
  end

endmodule
